// ----- rtl/core/ale_pkg.sv -----
// types, constants and action codes for the array list engine
`timescale 1ns / 1ps
package ale_pkg;

   localparam int CAPACITY = 128;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ACT_W    = 3;
   localparam int POS_W    = 7;
   localparam int WORD_W   = 32;
   localparam int LEN_W    = 8;

   localparam logic [ACT_W-1:0] ACT_READ      = 3'd0;
   localparam logic [ACT_W-1:0] ACT_APPEND    = 3'd1;
   localparam logic [ACT_W-1:0] ACT_INSERT    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_RM_LAST   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_RM_FIRST  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_RM_AT     = 3'd5;

   localparam logic signed [WORD_W-1:0] READ_FAIL = -32'sd1;

   typedef struct packed {
      logic [ACT_W-1:0]         action;
      logic [POS_W-1:0]         position;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     ok;
      logic signed [WORD_W-1:0] read_value;
      logic [LEN_W-1:0]         length;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_FINISH
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic idx_init;
      logic idx_step;
      logic rd_pos;
      logic rd_move;
      logic wr_move;
      logic finish;
   } ctl_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             legal;
      logic             move_more;
      logic             rsp_busy;
   } sts_type;

endpackage

// ----- rtl/core/ale_ctrl.sv -----
// sequencer for the array list engine: decode, shift loop and result hand-off
`timescale 1ns / 1ps
module ale_ctrl
   import ale_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output ctl_type ctl
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_FINISH;
            if (sts.legal) begin
               case (sts.action)
                  ACT_READ: begin
                     ctl.rd_pos = 1'b1;
                  end
                  ACT_INSERT, ACT_RM_FIRST, ACT_RM_AT: begin
                     ctl.idx_init = 1'b1;
                     state_in     = ST_MOVE_RD;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_MOVE_RD: begin
            if (sts.move_more) begin
               ctl.rd_move = 1'b1;
               state_in    = ST_MOVE_WR;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MOVE_WR: begin
            ctl.wr_move  = 1'b1;
            ctl.idx_step = 1'b1;
            state_in     = ST_MOVE_RD;
         end
         ST_FINISH: begin
            if (!sts.rsp_busy) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/ale_dpath.sv -----
// datapath for the array list engine: entry memory, fill count, shift index, result register
`timescale 1ns / 1ps
module ale_dpath
   import ale_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  ctl_type ctl,
   output sts_type sts,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic signed [WORD_W-1:0] entries_ff [CAPACITY];
   logic signed [WORD_W-1:0] rdata_ff;

   logic [ACT_W-1:0]         action_ff;
   logic [POS_W-1:0]         pos_ff;
   logic signed [WORD_W-1:0] value_ff;

   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;
   logic [CNT_W-1:0] idx_ff;
   logic [CNT_W-1:0] idx_in;
   logic [CNT_W-1:0] idx_inc;
   logic [CNT_W-1:0] idx_dec;
   logic [CNT_W-1:0] pos_cnt;

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic pos_in_range;
   logic not_full;
   logic not_empty;
   logic legal;
   logic is_insert;
   logic grows;
   logic shrinks;

   logic                     mem_we;
   logic                     mem_re;
   logic [IDX_W-1:0]         wr_addr;
   logic [IDX_W-1:0]         rd_addr;
   logic [CNT_W-1:0]         rd_src;
   logic signed [WORD_W-1:0] wr_data;

   // request capture
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         action_ff <= req_data.action;
         pos_ff    <= req_data.position;
         value_ff  <= req_data.value;
      end
   end

   // legality and loop status
   always_comb begin
      pos_in_range = 32'(pos_ff) < 32'(fill_ff);
      not_full     = fill_ff < CNT_W'(CAPACITY);
      not_empty    = fill_ff != '0;
      pos_cnt      = CNT_W'(pos_ff);
      idx_inc      = idx_ff + CNT_W'(1);
      idx_dec      = idx_ff - CNT_W'(1);
      is_insert    = action_ff == ACT_INSERT;
      case (action_ff)
         ACT_READ:     legal = pos_in_range;
         ACT_APPEND:   legal = not_full;
         ACT_INSERT:   legal = not_full;
         ACT_RM_LAST:  legal = not_empty;
         ACT_RM_FIRST: legal = not_empty;
         ACT_RM_AT:    legal = pos_in_range;
         default:      legal = 1'b0;
      endcase
      grows   = legal && (action_ff == ACT_APPEND || action_ff == ACT_INSERT);
      shrinks = legal && (action_ff == ACT_RM_LAST || action_ff == ACT_RM_FIRST ||
                          action_ff == ACT_RM_AT);
   end

   assign sts.action    = action_ff;
   assign sts.legal     = legal;
   assign sts.move_more = is_insert ? (idx_ff != '0) : (idx_inc < fill_ff);
   assign sts.rsp_busy  = rsp_valid_ff && rsp_stall;

   // shift index
   always_comb begin
      idx_in = idx_ff;
      if (ctl.idx_init) begin
         if (is_insert) begin
            idx_in = fill_ff;
         end else if (action_ff == ACT_RM_FIRST) begin
            idx_in = '0;
         end else begin
            idx_in = pos_cnt;
         end
      end else if (ctl.idx_step) begin
         idx_in = is_insert ? idx_dec : idx_inc;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // memory port selection
   always_comb begin
      rd_src  = is_insert ? idx_dec : idx_inc;
      mem_re  = ctl.rd_pos || ctl.rd_move;
      rd_addr = ctl.rd_move ? rd_src[IDX_W-1:0] : pos_cnt[IDX_W-1:0];
      mem_we  = ctl.wr_move || (ctl.finish && grows);
      if (ctl.finish) begin
         wr_addr = is_insert ? '0 : fill_ff[IDX_W-1:0];
         wr_data = value_ff;
      end else begin
         wr_addr = idx_ff[IDX_W-1:0];
         wr_data = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_ff[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rdata_ff <= entries_ff[rd_addr];
      end
   end

   // fill count
   always_comb begin
      fill_in = fill_ff;
      if (ctl.finish) begin
         if (grows) begin
            fill_in = fill_ff + CNT_W'(1);
         end else if (shrinks) begin
            fill_in = fill_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // result register
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_in.ok     = legal;
      rsp_in.length = LEN_W'(fill_in);
      if (action_ff == ACT_READ) begin
         rsp_in.read_value = legal ? rdata_ff : READ_FAIL;
      end else begin
         rsp_in.read_value = '0;
      end
      if (ctl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/core/array_list_engine_top.sv -----
// array list engine top level: sequencer plus datapath
//
//   port group   dir   beat carries
//   req_*        in    action, position, value
//   rsp_*        out   ok, read_value, length
//
// read, append, remove-last and failed actions: the beat passes ST_DECIDE and then ST_FINISH,
// and the result is registered once ST_FINISH sees no stalled result ahead of it
// insert-front and remove-first/at-index: in between, one ST_MOVE_RD and one ST_MOVE_WR per
// entry moved, since each move reads and then writes the entry memory
// reset empties the list at once; entries above the fill count are never read
// a waiting result sits in the output register; a new beat is taken meanwhile
`timescale 1ns / 1ps
module array_list_engine_top
   import ale_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctl_type ctl;
   sts_type sts;

   ale_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   ale_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
